### design/grid_ray_caster_macros.svh
// Assertion macros for the grid ray caster
`ifndef GRID_RAY_CASTER_MACROS_SVH
`define GRID_RAY_CASTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GRC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define GRC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/grc_pkg.sv
// Shared types, constants and tables of the grid ray caster
package grc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TW   = 19;
	localparam int ZW   = 22;
	localparam int DW   = 36;
	localparam int NUMW = 33;
	localparam int DENW = 38;

	localparam logic signed [TW-1:0] CORDIC_GAIN = 19'sd39797;
	localparam logic [DW-1:0]        AXIS_NEVER  = 36'h2_0000_0000;
	localparam logic [NUMW-1:0]      RECIP_NUM   = 33'h1_0000_0000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RAY   = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CRAY,
		ST_DX,
		ST_DXW,
		ST_DY,
		ST_DYW,
		ST_SX,
		ST_SY,
		ST_START,
		ST_STEP,
		ST_READ,
		ST_CHECK,
		ST_COORD,
		ST_TEX,
		ST_CVW,
		ST_PERP,
		ST_HD,
		ST_HDW,
		ST_OUT
	} state_t;

	function automatic logic signed [ZW-1:0] atan_units(input logic [3:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			4'd0:    v = 22'sd131072;
			4'd1:    v = 22'sd77376;
			4'd2:    v = 22'sd40884;
			4'd3:    v = 22'sd20753;
			4'd4:    v = 22'sd10417;
			4'd5:    v = 22'sd5213;
			4'd6:    v = 22'sd2607;
			4'd7:    v = 22'sd1304;
			4'd8:    v = 22'sd652;
			4'd9:    v = 22'sd326;
			4'd10:   v = 22'sd163;
			4'd11:   v = 22'sd81;
			4'd12:   v = 22'sd41;
			4'd13:   v = 22'sd20;
			4'd14:   v = 22'sd10;
			4'd15:   v = 22'sd5;
			default: v = 22'sd0;
		endcase
		return v;
	endfunction

endpackage

### design/grc_ram.sv
// Generic simple dual-port RAM with registered read
module grc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/grc_cordic.sv
// Iterative CORDIC: cosine and sine of a 12-bit binary angle, one stage a cycle
module grc_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [11:0]                    angle,
	output logic                           done,
	output logic signed [grc_pkg::TW-1:0]  cos_val,
	output logic signed [grc_pkg::TW-1:0]  sin_val
);

	logic signed [grc_pkg::TW-1:0] x_q, y_q, dx, dy;
	logic signed [grc_pkg::ZW-1:0] z_q, z0;
	logic signed [12:0]            a0, a1;
	logic                          flip0;
	logic                          flip_q, busy_q, done_q;
	logic [3:0]                    i_q;

	always_comb begin
		a0    = $signed({angle[11], angle});
		flip0 = 1'b0;
		a1    = a0;
		if (a0 > 13'sd1024) begin
			a1    = a0 - 13'sd2048;
			flip0 = 1'b1;
		end else if (a0 < -13'sd1024) begin
			a1    = a0 + 13'sd2048;
			flip0 = 1'b1;
		end
		z0 = $signed({a1[12], a1, 8'h00});
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= 4'd0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(grc_pkg::CORDIC_STAGES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= grc_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= z0;
			flip_q <= flip0;
		end else if (busy_q) begin
			if (!z_q[grc_pkg::ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - grc_pkg::atan_units(i_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + grc_pkg::atan_units(i_q);
			end
		end
	end

	assign done    = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

### design/grc_div.sv
// Restoring divider, one quotient bit a cycle
module grc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [grc_pkg::NUMW-1:0]    num,
	input  logic [grc_pkg::DENW-1:0]    den,
	output logic                        done,
	output logic [grc_pkg::NUMW-1:0]    quo
);

	localparam int CNTW = $clog2(grc_pkg::NUMW);

	logic [grc_pkg::NUMW-1:0] q_q;
	logic [grc_pkg::DENW-1:0] rem_q, den_q, rem_d;
	logic [grc_pkg::DENW:0]   trial;
	logic                     ge, busy_q, done_q;
	logic [CNTW-1:0]          cnt_q;

	always_comb begin
		trial = {rem_q, q_q[grc_pkg::NUMW-1]};
		ge    = trial >= {1'b0, den_q};
		if (ge) begin
			rem_d = grc_pkg::DENW'(trial - {1'b0, den_q});
		end else begin
			rem_d = trial[grc_pkg::DENW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(grc_pkg::NUMW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[grc_pkg::NUMW-2:0], ge};
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

### design/grid_ray_caster.sv
// Grid ray caster top level: tile map, DDA sequencer and shared arithmetic
//
//  channel | direction | handshake              | contents
//  s_*     | in        | s_tvalid / s_tready    | map write or ray cast
//  m_*     | out       | m_tvalid / m_tready    | ray result
//  cfg_*   | in        | cfg_we                 | projection_scale
//
// After reset a clearing pass writes zero to all MAP_SIZE*MAP_SIZE cells (4096 by
// default), with s_tready low. A ray that hits runs two CORDIC passes and three
// divisions through the shared divider, with one RAM read per map cell stepped; a
// miss skips the second CORDIC pass and the height division, a zero sine or cosine
// its own division.
// A result waits in the output register while the next transaction is taken.
`include "grid_ray_caster_macros.svh"

module grid_ray_caster #(
	parameter int MAP_SIZE        = 64,
	parameter int TEXTURE_COLUMNS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_x, cell_y, cell_value, pos_x, pos_y, ray_angle, view_angle
	input  logic [71:0] s_tdata,
	// operation
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// hit_x, hit_y, wall_type, hit_side, ray_distance, texture_column,
	// projected_height, zero padding
	output logic [63:0] m_tdata,
	// hit_found
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int DEPTH = MAP_SIZE * MAP_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (($clog2(MAP_SIZE) > 6) ? $clog2(MAP_SIZE) : 6) + 2;
	localparam int LIMIT = 2 * MAP_SIZE + 2;
	localparam int IW    = $clog2(LIMIT);
	localparam int TW    = grc_pkg::TW;
	localparam int DW    = grc_pkg::DW;
	localparam int MW    = DW + TW + 1;

	grc_pkg::state_t state_q, state_d;

	logic [AW-1:0]  clr_q;
	logic [15:0]    scale_q;
	logic [13:0]    px_q, py_q;
	logic [11:0]    ra_q, va_q;
	logic signed [TW-1:0] rc_q, rs_q, vc_q;
	logic [DW-1:0]  dx_q, dy_q, sx_q, sy_q, dist_q;
	logic [CW-1:0]  cx_q, cy_q;
	logic           side_q, hit_q;
	logic [7:0]     wall_q;
	logic [IW-1:0]  iter_q;
	logic [5:0]     tex_q;
	logic [15:0]    h_q;

	logic           m_tvalid_q, m_tuser_q;
	logic [63:0]    m_tdata_q;

	logic           accept, out_load;
	logic [5:0]     in_cell_x, in_cell_y;
	logic [7:0]     in_cell_value;
	logic [13:0]    in_pos_x, in_pos_y;
	logic [11:0]    in_ray_angle, in_view_angle;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;
	logic           cell_out;

	logic           cordic_start, cordic_done;
	logic [11:0]    cordic_angle;
	logic signed [TW-1:0] cordic_cos, cordic_sin;

	logic           div_start, div_done;
	logic [grc_pkg::NUMW-1:0] div_num, div_quo;
	logic [grc_pkg::DENW-1:0] div_den;

	logic signed [DW:0]   mul_a;
	logic signed [TW-1:0] mul_b;
	logic signed [MW-1:0] mul_q;

	logic [TW-1:0]  rc_abs, rs_abs;
	logic [8:0]     fxm, fym;
	logic [15:0]    frac;
	logic [24:0]    tprod;
	logic signed [MW-17:0] perp;
	logic           perp_pos;
	logic [15:0]    rd_sat;

	assign in_cell_x     = s_tdata[5:0];
	assign in_cell_y     = s_tdata[11:6];
	assign in_cell_value = s_tdata[19:12];
	assign in_pos_x      = s_tdata[33:20];
	assign in_pos_y      = s_tdata[47:34];
	assign in_ray_angle  = s_tdata[59:48];
	assign in_view_angle = s_tdata[71:60];

	assign s_tready = (state_q == grc_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == grc_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	assign rc_abs   = rc_q[TW-1] ? TW'(-rc_q) : rc_q;
	assign rs_abs   = rs_q[TW-1] ? TW'(-rs_q) : rs_q;
	assign fxm      = rc_q[TW-1] ? {1'b0, px_q[7:0]} : 9'd256 - {1'b0, px_q[7:0]};
	assign fym      = rs_q[TW-1] ? {1'b0, py_q[7:0]} : 9'd256 - {1'b0, py_q[7:0]};
	assign frac     = side_q ? ({px_q[7:0], 8'h00} + mul_q[31:16])
	                         : ({py_q[7:0], 8'h00} + mul_q[31:16]);
	assign tprod    = 25'(frac) * 25'(TEXTURE_COLUMNS);
	assign perp     = mul_q[MW-1:16];
	assign perp_pos = !perp[MW-17] && (|perp);
	assign rd_sat   = (|dist_q[DW-1:24]) ? 16'hFFFF : dist_q[23:8];
	assign cell_out = ($unsigned(cx_q) >= CW'(MAP_SIZE)) || ($unsigned(cy_q) >= CW'(MAP_SIZE));

	always_comb begin
		ram_raddr = AW'(AW'(cy_q) * AW'(MAP_SIZE) + AW'(cx_q));
		ram_wdata = 8'h00;
		ram_waddr = clr_q;
		ram_we    = 1'b0;
		if (state_q == grc_pkg::ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (accept && (s_tuser == grc_pkg::OP_WRITE)
		             && ({3'b000, in_cell_x} < 9'(MAP_SIZE))
		             && ({3'b000, in_cell_y} < 9'(MAP_SIZE))) begin
			ram_we    = 1'b1;
			ram_wdata = in_cell_value;
			ram_waddr = AW'(AW'(in_cell_y) * AW'(MAP_SIZE) + AW'(in_cell_x));
		end
	end

	always_comb begin
		cordic_start = 1'b0;
		cordic_angle = in_ray_angle;
		div_start    = 1'b0;
		div_num      = grc_pkg::RECIP_NUM;
		div_den      = {{(grc_pkg::DENW-TW){1'b0}}, rc_abs};
		mul_a        = $signed({1'b0, dx_q});
		mul_b        = $signed({{(TW-9){1'b0}}, fxm});
		case (state_q)
			grc_pkg::ST_IDLE: begin
				cordic_start = accept && (s_tuser == grc_pkg::OP_RAY);
			end
			grc_pkg::ST_DX: begin
				div_start = |rc_q;
			end
			grc_pkg::ST_DY: begin
				div_start = |rs_q;
				div_den   = {{(grc_pkg::DENW-TW){1'b0}}, rs_abs};
			end
			grc_pkg::ST_SY: begin
				mul_a = $signed({1'b0, dy_q});
				mul_b = $signed({{(TW-9){1'b0}}, fym});
			end
			grc_pkg::ST_COORD: begin
				mul_a = $signed({1'b0, dist_q});
				mul_b = side_q ? rc_q : rs_q;
			end
			grc_pkg::ST_TEX: begin
				cordic_start = 1'b1;
				cordic_angle = va_q - ra_q;
			end
			grc_pkg::ST_PERP: begin
				mul_a = $signed({1'b0, dist_q});
				mul_b = vc_q;
			end
			grc_pkg::ST_HD: begin
				div_start = perp_pos;
				div_num   = {1'b0, scale_q, 16'h0000};
				div_den   = perp[grc_pkg::DENW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			grc_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = grc_pkg::ST_IDLE;
			end
			grc_pkg::ST_IDLE: begin
				if (accept && (s_tuser == grc_pkg::OP_RAY)) state_d = grc_pkg::ST_CRAY;
			end
			grc_pkg::ST_CRAY: begin
				if (cordic_done) state_d = grc_pkg::ST_DX;
			end
			grc_pkg::ST_DX: begin
				state_d = (|rc_q) ? grc_pkg::ST_DXW : grc_pkg::ST_DY;
			end
			grc_pkg::ST_DXW: begin
				if (div_done) state_d = grc_pkg::ST_DY;
			end
			grc_pkg::ST_DY: begin
				state_d = (|rs_q) ? grc_pkg::ST_DYW : grc_pkg::ST_SX;
			end
			grc_pkg::ST_DYW: begin
				if (div_done) state_d = grc_pkg::ST_SX;
			end
			grc_pkg::ST_SX:    state_d = grc_pkg::ST_SY;
			grc_pkg::ST_SY:    state_d = grc_pkg::ST_START;
			grc_pkg::ST_START: state_d = cell_out ? grc_pkg::ST_OUT : grc_pkg::ST_STEP;
			grc_pkg::ST_STEP:  state_d = grc_pkg::ST_READ;
			grc_pkg::ST_READ:  state_d = cell_out ? grc_pkg::ST_OUT : grc_pkg::ST_CHECK;
			grc_pkg::ST_CHECK: begin
				if (ram_rdata != 8'h00) begin
					state_d = grc_pkg::ST_COORD;
				end else if (iter_q == IW'(LIMIT - 1)) begin
					state_d = grc_pkg::ST_OUT;
				end else begin
					state_d = grc_pkg::ST_STEP;
				end
			end
			grc_pkg::ST_COORD: state_d = grc_pkg::ST_TEX;
			grc_pkg::ST_TEX:   state_d = grc_pkg::ST_CVW;
			grc_pkg::ST_CVW: begin
				if (cordic_done) state_d = grc_pkg::ST_PERP;
			end
			grc_pkg::ST_PERP:  state_d = grc_pkg::ST_HD;
			grc_pkg::ST_HD:    state_d = perp_pos ? grc_pkg::ST_HDW : grc_pkg::ST_OUT;
			grc_pkg::ST_HDW: begin
				if (div_done) state_d = grc_pkg::ST_OUT;
			end
			grc_pkg::ST_OUT: begin
				if (out_load) state_d = grc_pkg::ST_IDLE;
			end
			default: state_d = grc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= grc_pkg::ST_CLEAR;
			clr_q      <= '0;
			scale_q    <= 16'd16384;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == grc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= MW'(mul_a * mul_b);
		case (state_q)
			grc_pkg::ST_IDLE: begin
				px_q   <= in_pos_x;
				py_q   <= in_pos_y;
				ra_q   <= in_ray_angle;
				va_q   <= in_view_angle;
				cx_q   <= CW'(in_pos_x[13:8]);
				cy_q   <= CW'(in_pos_y[13:8]);
				hit_q  <= 1'b0;
				iter_q <= '0;
				side_q <= 1'b0;
				dist_q <= '0;
			end
			grc_pkg::ST_CRAY: begin
				rc_q <= cordic_cos;
				rs_q <= cordic_sin;
			end
			grc_pkg::ST_DX: begin
				dx_q <= grc_pkg::AXIS_NEVER;
			end
			grc_pkg::ST_DXW: begin
				dx_q <= DW'(div_quo);
			end
			grc_pkg::ST_DY: begin
				dy_q <= grc_pkg::AXIS_NEVER;
			end
			grc_pkg::ST_DYW: begin
				dy_q <= DW'(div_quo);
			end
			grc_pkg::ST_SY: begin
				sx_q <= mul_q[DW+7:8];
			end
			grc_pkg::ST_START: begin
				sy_q <= mul_q[DW+7:8];
			end
			grc_pkg::ST_STEP: begin
				if (sx_q < sy_q) begin
					dist_q <= sx_q;
					sx_q   <= sx_q + dx_q;
					cx_q   <= rc_q[TW-1] ? cx_q - CW'(1) : cx_q + CW'(1);
					side_q <= 1'b0;
				end else begin
					dist_q <= sy_q;
					sy_q   <= sy_q + dy_q;
					cy_q   <= rs_q[TW-1] ? cy_q - CW'(1) : cy_q + CW'(1);
					side_q <= 1'b1;
				end
			end
			grc_pkg::ST_CHECK: begin
				wall_q <= ram_rdata;
				hit_q  <= ram_rdata != 8'h00;
				iter_q <= iter_q + IW'(1);
			end
			grc_pkg::ST_TEX: begin
				tex_q <= tprod[21:16];
			end
			grc_pkg::ST_CVW: begin
				vc_q <= cordic_cos;
			end
			grc_pkg::ST_HD: begin
				h_q <= 16'hFFFF;
			end
			grc_pkg::ST_HDW: begin
				h_q <= (|div_quo[grc_pkg::NUMW-1:16]) ? 16'hFFFF : div_quo[15:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_tuser_q <= hit_q;
			if (hit_q) begin
				m_tdata_q <= {5'b00000, h_q, tex_q, rd_sat, side_q, wall_q,
				              cy_q[5:0], cx_q[5:0]};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	grc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	grc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (cordic_angle),
		.done   (cordic_done),
		.cos_val(cordic_cos),
		.sin_val(cordic_sin)
	);

	grc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	`GRC_ASSERT_IMP(a_hit_wall, m_tvalid && m_tuser, m_tdata[19:12] != 8'h00, "hit without wall")
	`GRC_ASSERT_IMP(a_cordic_when, cordic_done, state_q == grc_pkg::ST_CRAY || state_q == grc_pkg::ST_CVW, "stray cordic done")
	`GRC_ASSERT_IMP(a_div_when, div_done, state_q == grc_pkg::ST_DXW || state_q == grc_pkg::ST_DYW || state_q == grc_pkg::ST_HDW, "stray divider done")
	`GRC_ASSERT_NXT(a_out_load, out_load, m_tvalid, "result not presented")

endmodule

### sim/tb.sv
// Testbench for grid_ray_caster: directed and random map writes and ray casts checked against a predictor
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic        op;
		logic [5:0]  cx;
		logic [5:0]  cy;
		logic [7:0]  val;
		logic [13:0] px;
		logic [13:0] py;
		logic [11:0] ra;
		logic [11:0] va;
	} cast_req_t;

	typedef struct packed {
		logic        hit;
		logic [5:0]  hx;
		logic [5:0]  hy;
		logic [7:0]  wall;
		logic        side;
		logic [15:0] rd;
		logic [5:0]  tex;
		logic [15:0] ht;
	} cast_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	cast_req_t   pend_q[$];
	cast_res_t   hits_q[$];
	logic [7:0]  tile_copy[4096];
	logic [15:0] scale_copy = 16'd16384;
	int          n_errors = 0;
	int          n_writes = 0;
	int          n_rays = 0;
	int          n_hits = 0;
	int          n_miss = 0;
	bit          no_idle = 1'b0;
	bit          hold_req = 1'b0;
	int          gap_cnt = 0;
	int          burst_cnt = 0;
	int          hold_cnt = 0;
	bit          hold_used = 1'b0;

	localparam longint ATAN_TAB[16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
		652, 326, 163, 81, 41, 20, 10, 5};

	grid_ray_caster i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void sin_cos(input logic [11:0] ang, output longint c, output longint s);
		int     a;
		bit     flip;
		longint x, y, z, ddx, ddy;
		a = int'(ang);
		flip = 1'b0;
		x = 39797;
		y = 0;
		if (a >= 2048) a -= 4096;
		if (a > 1024) begin
			a -= 2048;
			flip = 1'b1;
		end else if (a < -1024) begin
			a += 2048;
			flip = 1'b1;
		end
		z = longint'(a) * 256;
		for (int i = 0; i < 16; i++) begin
			ddx = y >>> i;
			ddy = x >>> i;
			if (z >= 0) begin
				x -= ddx; y += ddy; z -= ATAN_TAB[i];
			end else begin
				x += ddx; y -= ddy; z += ATAN_TAB[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint cell_step(input longint t);
		longint m;
		m = (t < 0) ? -t : t;
		if (m == 0) return longint'(1) << 33;
		return (longint'(1) << 32) / m;
	endfunction

	function automatic void cast_ray(input cast_req_t r);
		longint rc, rs, vc, vs, ddx, ddy, sdx, sdy, ray_len, coord, perp, hgt, rdist;
		int        cx, cy, stx, sty, side;
		bit        hit;
		logic [7:0] wall;
		cast_res_t e;
		sin_cos(r.ra, rc, rs);
		ddx = cell_step(rc);
		ddy = cell_step(rs);
		cx = int'(r.px >> 8);
		cy = int'(r.py >> 8);
		if (rc < 0) begin
			stx = -1; sdx = (longint'(r.px[7:0]) * ddx) >> 8;
		end else begin
			stx = 1; sdx = (longint'(256 - r.px[7:0]) * ddx) >> 8;
		end
		if (rs < 0) begin
			sty = -1; sdy = (longint'(r.py[7:0]) * ddy) >> 8;
		end else begin
			sty = 1; sdy = (longint'(256 - r.py[7:0]) * ddy) >> 8;
		end
		hit = 1'b0;
		side = 0;
		ray_len = 0;
		wall = '0;
		for (int i = 0; i < 130; i++) begin
			if (sdx < sdy) begin
				ray_len = sdx; sdx += ddx; cx += stx; side = 0;
			end else begin
				ray_len = sdy; sdy += ddy; cy += sty; side = 1;
			end
			if (cx < 0 || cy < 0 || cx >= 64 || cy >= 64) break;
			wall = tile_copy[cy * 64 + cx];
			if (wall != 0) begin
				hit = 1'b1;
				break;
			end
		end
		e = '0;
		n_rays++;
		if (hit) begin
			n_hits++;
			if (side == 1) coord = longint'(r.px) * 256 + ((ray_len * rc) >>> 16);
			else coord = longint'(r.py) * 256 + ((ray_len * rs) >>> 16);
			sin_cos(r.va - r.ra, vc, vs);
			perp = (ray_len * vc) >>> 16;
			if (perp <= 0) hgt = 65535;
			else begin
				hgt = (longint'(scale_copy) << 16) / perp;
				if (hgt > 65535) hgt = 65535;
			end
			rdist = ray_len >> 8;
			if (rdist > 65535) rdist = 65535;
			e.hit = 1'b1;
			e.hx = cx[5:0];
			e.hy = cy[5:0];
			e.wall = wall;
			e.side = side[0];
			e.rd = rdist[15:0];
			e.tex = 6'(((coord & 16'hFFFF) * 64) >> 16);
			e.ht = hgt[15:0];
		end else begin
			n_miss++;
		end
		hits_q.push_back(e);
	endfunction

	function automatic logic [71:0] pack_req(input cast_req_t r);
		return {r.va, r.ra, r.py, r.px, r.val, r.cy, r.cx};
	endfunction

	// sender: bursts with random gaps, hold the item until taken
	always @(posedge clk) begin
		cast_req_t r;
		logic      v;
		logic [71:0] d;
		logic      u;
		v = s_tvalid;
		d = s_tdata;
		u = s_tuser;
		if (s_tvalid && s_tready) begin
			r = pend_q.pop_front();
			if (r.op == grc_pkg::OP_WRITE) begin
				tile_copy[{r.cy, r.cx}] = r.val;
				n_writes++;
			end else begin
				cast_ray(r);
			end
		end
		if (!(s_tvalid && !s_tready)) begin
			if (gap_cnt > 0 && !no_idle) begin
				gap_cnt--;
				v = 1'b0;
			end else if (pend_q.size() > 0) begin
				v = 1'b1;
				d = pack_req(pend_q[0]);
				u = pend_q[0].op;
				if (burst_cnt > 0) burst_cnt--;
				else begin
					burst_cnt = $urandom_range(0, 30);
					gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				v = 1'b0;
			end
		end
		s_tvalid <= v;
		s_tdata <= d;
		s_tuser <= u;
	end

	// receiver: random stall pattern, one long hold-off on request
	always @(posedge clk) begin
		logic rdy;
		if (hold_req && !hold_used) begin
			hold_used = 1'b1;
			hold_cnt = 4000;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rdy = 1'b0;
		end else if (no_idle) begin
			rdy = 1'b1;
		end else begin
			rdy = ($urandom_range(0, 4) != 0);
		end
		m_tready <= rdy;
	end

	task automatic chk(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		cast_res_t e;
		if (m_tvalid && m_tready) begin
			if (hits_q.size() == 0) begin
				$error("result transaction with none expected");
				n_errors++;
			end else begin
				e = hits_q.pop_front();
				chk("hit_found", e.hit, m_tuser);
				chk("hit_x", e.hx, m_tdata[5:0]);
				chk("hit_y", e.hy, m_tdata[11:6]);
				chk("wall_type", e.wall, m_tdata[19:12]);
				chk("hit_side", e.side, m_tdata[20]);
				chk("ray_distance", e.rd, m_tdata[36:21]);
				chk("texture_column", e.tex, m_tdata[42:37]);
				chk("projected_height", e.ht, m_tdata[58:43]);
			end
		end
	end

	function automatic cast_req_t ray_req(input int px, input int py, input int ra, input int va);
		cast_req_t r;
		r = '0;
		r.op = grc_pkg::OP_RAY;
		r.px = 14'(px); r.py = 14'(py); r.ra = 12'(ra); r.va = 12'(va);
		return r;
	endfunction

	function automatic cast_req_t cell_req(input int cx, input int cy, input int val);
		cast_req_t r;
		r = '0;
		r.op = grc_pkg::OP_WRITE;
		r.cx = 6'(cx); r.cy = 6'(cy); r.val = 8'(val);
		return r;
	endfunction

	function automatic cast_req_t rand_req();
		cast_req_t r;
		int ra;
		r = '0;
		if ($urandom_range(0, 9) < 4) begin
			r = cell_req($urandom_range(0, 63), $urandom_range(0, 63),
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
			r.px = 14'($urandom); r.py = 14'($urandom);
			r.ra = 12'($urandom); r.va = 12'($urandom);
		end else begin
			ra = ($urandom_range(0, 7) == 0) ? 1024 * $urandom_range(0, 3) : $urandom_range(0, 4095);
			r = ray_req($urandom_range(0, 16383), $urandom_range(0, 16383), ra,
				($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : ra + $urandom_range(0, 700) - 350);
			r.cx = 6'($urandom); r.cy = 6'($urandom); r.val = 8'($urandom);
		end
		return r;
	endfunction

	task automatic drain();
		while (pend_q.size() > 0 || hits_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_scale(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_copy = v;
	endtask

	task automatic random_phase(input int n);
		repeat (n) pend_q.push_back(rand_req());
		drain();
	endtask

	initial begin
		foreach (tile_copy[i]) tile_copy[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		pend_q.push_back(ray_req(8192, 8192, 0, 0));
		pend_q.push_back(cell_req(0, 0, 255));
		pend_q.push_back(cell_req(63, 63, 1));
		pend_q.push_back(cell_req(63, 0, 128));
		pend_q.push_back(cell_req(0, 63, 77));
		pend_q.push_back(ray_req(0, 0, 0, 0));
		pend_q.push_back(ray_req(16383, 16383, 2048, 2048));
		pend_q.push_back(ray_req(128, 16200, 3072, 3072));
		pend_q.push_back(ray_req(16300, 100, 1024, 1024));
		pend_q.push_back(ray_req(8000, 8000, 512, 2560));
		pend_q.push_back(ray_req(8000, 8000, 512, 1536));
		pend_q.push_back(ray_req(8192, 8192, 512, 512));
		pend_q.push_back(ray_req(8300, 8250, 4095, 0));
		pend_q.push_back(ray_req(1000, 1000, 2560, 2600));
		pend_q.push_back(cell_req(0, 0, 0));
		pend_q.push_back(ray_req(1000, 1000, 2560, 2600));
		for (int i = 0; i < 64; i++) begin
			pend_q.push_back(cell_req(i, 32, 1 + i));
			pend_q.push_back(cell_req(32, i, 200 - i));
		end
		drain();

		set_scale(16'hFFFF);
		random_phase(420);
		set_scale(16'h0000);
		hold_req <= 1'b1;
		random_phase(420);
		no_idle = 1'b1;
		set_scale(16'($urandom));
		random_phase(200);
		no_idle = 1'b0;
		set_scale(16'd1);
		random_phase(150);

		repeat (700) @(posedge clk);
		$display("covered %0d map writes and %0d rays (%0d hits, %0d misses)",
			n_writes, n_rays, n_hits, n_miss);
		$display("scales 16384, 65535, 0, random and 1; one long output hold-off");
		if (n_errors == 0 && hits_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/grc_pkg.sv
design/grc_ram.sv
design/grc_cordic.sv
design/grc_div.sv
design/grid_ray_caster.sv
sim/tb.sv
